### rtl/tlfs_pkg.sv
// Shared types and constants for the two-level feedback scheduler.
// Used by tlfs_cell, tlfs_head and the top level; no dependencies.
package tlfs_pkg;

    localparam int DEF_SLOT_COUNT   = 16;
    localparam int DEF_QUEUE_LEVELS = 2;

    localparam logic [0:0] CFG_FAST_QUANTUM  = 1'b0;
    localparam logic [0:0] CFG_SMART_QUANTUM = 1'b1;

    localparam logic [7:0] FAST_QUANTUM_RST  = 8'd2;
    localparam logic [7:0] SMART_QUANTUM_RST = 8'd4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [31:0] WAIT_MAX = 32'hFFFF_FFFF;

    // one process slot as it travels around the ring
    typedef struct packed {
        logic        valid;
        logic        in_smart;
        logic [15:0] job;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [15:0] run_ticks;
        logic [31:0] wait_ticks;
        logic [7:0]  q_ticks;
        logic [15:0] stamp;
    } t_slot;

    typedef enum logic [1:0] {
        PH_HOLD,
        PH_ADD,
        PH_PICK,
        PH_UPDATE
    } t_phase;

    // control handed to the head stage
    typedef struct packed {
        t_phase      phase;
        logic        is_run;
        logic        leave;
        logic [15:0] pick_stamp;
        logic [15:0] counter;
        logic [7:0]  quantum;
        logic        add_found;
        logic [15:0] add_job;
        logic [15:0] add_burst;
        logic [15:0] add_arrival;
        logic        bf_found;
        logic [15:0] bf_arrival;
        logic [15:0] bf_job;
        logic [15:0] bf_stamp;
        logic        bs_found;
        logic [31:0] bs_wait;
        logic [15:0] bs_run;
        logic [15:0] bs_stamp;
    } t_head_ctl;

    typedef struct packed {
        logic fast_better;
        logic smart_better;
        logic add_take;
        logic finished;
        logic demoted;
    } t_head_res;

endpackage

### rtl/two_level_feedback_scheduler.sv
// Two-level feedback scheduler: fast queue by arrival, smart queue by wait/run ratio.
// Depends on tlfs_pkg, tlfs_cell and tlfs_head.
//
// The slot records sit in a ring of SLOT_COUNT cells that rotates one place per
// cycle, while an add, choose or update pass runs, through a single head stage,
// which does all comparing and updating; the ring holds still otherwise. An add
// makes one rotation; a tick with a job already running makes one rotation to
// update, and a tick with none makes one rotation to choose, a selection step
// and, if it found a job, one rotation to update. A result may wait for a full
// output register; the input is ready again in the cycle after the result is
// loaded there. One transaction is worked on at a time; a finished result waits
// in the output register while the next transaction is accepted.
module two_level_feedback_scheduler #(
    parameter int SLOT_COUNT   = tlfs_pkg::DEF_SLOT_COUNT,
    parameter int QUEUE_LEVELS = tlfs_pkg::DEF_QUEUE_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_burst_length,
    input  logic [15:0] i_arrival_stamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_run_id,
    output logic        o_finished,
    output logic        o_rejected,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(QUEUE_LEVELS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_PICK,
        S_SEL,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state;

    logic [7:0]    r_fast_q;
    logic [7:0]    r_smart_q;
    logic [IW-1:0] r_pos;
    logic [15:0]   r_counter;
    logic          r_run_valid;
    logic [IW-1:0] r_run_slot;
    logic [LW-1:0] r_run_level;
    logic          r_leave;
    logic [15:0]   r_pick_stamp;

    logic [15:0]   r_add_job;
    logic [15:0]   r_add_burst;
    logic [15:0]   r_add_arrival;
    logic          r_add_found;

    logic          r_bf_found;
    logic [15:0]   r_bf_arrival;
    logic [15:0]   r_bf_job;
    logic [15:0]   r_bf_stamp;
    logic [IW-1:0] r_bf_idx;
    logic          r_bs_found;
    logic [31:0]   r_bs_wait;
    logic [15:0]   r_bs_run;
    logic [15:0]   r_bs_stamp;
    logic [IW-1:0] r_bs_idx;

    logic [15:0]   r_res_run_id;
    logic          r_res_finished;
    logic          r_res_rejected;

    logic          r_out_valid;
    logic [15:0]   r_out_run_id;
    logic          r_out_finished;
    logic          r_out_rejected;

    tlfs_pkg::t_slot     cell_q [SLOT_COUNT];
    tlfs_pkg::t_slot     head_rec;
    tlfs_pkg::t_head_ctl head_ctl;
    tlfs_pkg::t_head_res head_res;
    tlfs_pkg::t_phase    phase;

    logic shift;
    logic last;
    logic is_run;
    logic in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign last       = (r_pos == IW'(SLOT_COUNT - 1));
    assign is_run     = r_run_valid && (r_pos == r_run_slot);

    always_comb begin
        case (r_state)
            S_ADD:   phase = tlfs_pkg::PH_ADD;
            S_PICK:  phase = tlfs_pkg::PH_PICK;
            S_UPD:   phase = tlfs_pkg::PH_UPDATE;
            default: phase = tlfs_pkg::PH_HOLD;
        endcase
    end

    assign shift = (phase != tlfs_pkg::PH_HOLD);

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_ring
            tlfs_pkg::t_slot cell_d;
            if (g == SLOT_COUNT - 1) begin : g_tail
                assign cell_d = head_rec;
            end else begin : g_mid
                assign cell_d = cell_q[g+1];
            end
            tlfs_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_d     (cell_d),
                .o_q     (cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        head_ctl             = '0;
        head_ctl.phase       = phase;
        head_ctl.is_run      = is_run;
        head_ctl.leave       = r_leave;
        head_ctl.pick_stamp  = r_pick_stamp;
        head_ctl.counter     = r_counter;
        head_ctl.quantum     = (r_run_level != '0) ? r_smart_q : r_fast_q;
        head_ctl.add_found   = r_add_found;
        head_ctl.add_job     = r_add_job;
        head_ctl.add_burst   = r_add_burst;
        head_ctl.add_arrival = r_add_arrival;
        head_ctl.bf_found    = r_bf_found;
        head_ctl.bf_arrival  = r_bf_arrival;
        head_ctl.bf_job      = r_bf_job;
        head_ctl.bf_stamp    = r_bf_stamp;
        head_ctl.bs_found    = r_bs_found;
        head_ctl.bs_wait     = r_bs_wait;
        head_ctl.bs_run      = r_bs_run;
        head_ctl.bs_stamp    = r_bs_stamp;
    end

    tlfs_head u_head (
        .i_rec (cell_q[0]),
        .i_ctl (head_ctl),
        .o_rec (head_rec),
        .o_res (head_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_q    <= tlfs_pkg::FAST_QUANTUM_RST;
            r_smart_q   <= tlfs_pkg::SMART_QUANTUM_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tlfs_pkg::CFG_FAST_QUANTUM) begin
                r_fast_q <= i_cfg_data;
            end else begin
                r_smart_q <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_counter   <= 16'd0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_run_level <= '0;
            r_leave     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (shift) begin
                r_pos <= last ? '0 : r_pos + IW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_add_job      <= i_job_id;
                        r_add_burst    <= i_burst_length;
                        r_add_arrival  <= i_arrival_stamp;
                        r_add_found    <= 1'b0;
                        r_bf_found     <= 1'b0;
                        r_bs_found     <= 1'b0;
                        r_leave        <= 1'b0;
                        r_res_run_id   <= 16'd0;
                        r_res_finished <= 1'b0;
                        r_res_rejected <= 1'b0;
                        if (i_cmd == tlfs_pkg::CMD_ADD) begin
                            r_state <= S_ADD;
                        end else if (r_run_valid) begin
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end
                end
                S_ADD: begin
                    if (head_res.add_take) begin
                        r_add_found <= 1'b1;
                    end
                    if (last) begin
                        if (r_add_found || head_res.add_take) begin
                            r_counter <= r_counter + 16'd1;
                        end else begin
                            r_res_rejected <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_PICK: begin
                    if (head_res.fast_better) begin
                        r_bf_found   <= 1'b1;
                        r_bf_arrival <= cell_q[0].arrival;
                        r_bf_job     <= cell_q[0].job;
                        r_bf_stamp   <= cell_q[0].stamp;
                        r_bf_idx     <= r_pos;
                    end
                    if (head_res.smart_better) begin
                        r_bs_found <= 1'b1;
                        r_bs_wait  <= cell_q[0].wait_ticks;
                        r_bs_run   <= cell_q[0].run_ticks;
                        r_bs_stamp <= cell_q[0].stamp;
                        r_bs_idx   <= r_pos;
                    end
                    if (last) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_bf_found || r_bs_found) begin
                        r_run_valid  <= 1'b1;
                        r_run_slot   <= r_bf_found ? r_bf_idx : r_bs_idx;
                        r_run_level  <= r_bf_found ? LW'(0) : LW'(1);
                        r_pick_stamp <= r_bf_found ? r_bf_stamp : r_bs_stamp;
                        r_leave      <= 1'b1;
                        if (r_counter != 16'd0) begin
                            r_counter <= r_counter - 16'd1;
                        end
                        r_state <= S_UPD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_UPD: begin
                    if (is_run) begin
                        r_res_run_id   <= cell_q[0].job;
                        r_res_finished <= head_res.finished;
                        if (head_res.finished || head_res.demoted) begin
                            r_run_valid <= 1'b0;
                        end
                        if (head_res.demoted) begin
                            r_counter <= r_counter + 16'd1;
                        end
                    end
                    if (last) begin
                        r_leave <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_run_id   <= r_res_run_id;
                        r_out_finished <= r_res_finished;
                        r_out_rejected <= r_res_rejected;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_run_id    = r_out_run_id;
    assign o_finished  = r_out_finished;
    assign o_rejected  = r_out_rejected;

`ifndef SYNTH
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos == '0))
        else $error("ring not aligned at idle");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (!o_finished && o_run_id == 16'd0))
        else $error("rejected add carries tick result");

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter <= 16'(SLOT_COUNT))
        else $error("queue rank counter exceeds slot count");

    a_run_from_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run_valid) |-> ($past(r_state) == S_SEL))
        else $error("running job set outside selection");
`endif

endmodule

### rtl/tlfs_cell.sv
// One slot cell of the scheduler ring: holds a slot record and passes it on.
// Depends on tlfs_pkg.
module tlfs_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  tlfs_pkg::t_slot i_d,
    output tlfs_pkg::t_slot o_q
);

    tlfs_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid    <= 1'b0;
            r_slot.in_smart <= 1'b0;
        end else if (i_shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

### rtl/tlfs_head.sv
// Head stage of the ring: compares and updates the slot record passing by.
// Depends on tlfs_pkg.
module tlfs_head (
    input  tlfs_pkg::t_slot     i_rec,
    input  tlfs_pkg::t_head_ctl i_ctl,
    output tlfs_pkg::t_slot     o_rec,
    output tlfs_pkg::t_head_res o_res
);

    logic        queued;
    logic        fast_wins;
    logic [49:0] lhs;
    logic [49:0] rhs;
    logic [15:0] run_inc;
    logic [7:0]  qu_inc;

    assign queued = i_rec.valid && !i_ctl.is_run;

    always_comb begin
        if (i_rec.arrival != i_ctl.bf_arrival) begin
            fast_wins = i_rec.arrival < i_ctl.bf_arrival;
        end else if (i_rec.job != i_ctl.bf_job) begin
            fast_wins = i_rec.job < i_ctl.bf_job;
        end else begin
            fast_wins = i_rec.stamp > i_ctl.bf_stamp;
        end
    end

    // exact ratio compare by cross-multiplication
    assign lhs = 50'(33'(i_rec.wait_ticks) + 33'd1) * 50'(17'(i_ctl.bs_run) + 17'd1);
    assign rhs = 50'(33'(i_ctl.bs_wait) + 33'd1) * 50'(17'(i_rec.run_ticks) + 17'd1);

    assign run_inc = i_rec.run_ticks + 16'd1;
    assign qu_inc  = i_rec.q_ticks + 8'd1;

    always_comb begin
        o_rec = i_rec;
        o_res = '0;
        case (i_ctl.phase)
            tlfs_pkg::PH_ADD: begin
                if (!i_rec.valid && !i_ctl.add_found) begin
                    o_rec.valid        = 1'b1;
                    o_rec.in_smart     = 1'b0;
                    o_rec.job          = i_ctl.add_job;
                    o_rec.burst        = (i_ctl.add_burst == 16'd0) ? 16'd1 : i_ctl.add_burst;
                    o_rec.arrival      = i_ctl.add_arrival;
                    o_rec.run_ticks    = 16'd0;
                    o_rec.wait_ticks   = 32'd0;
                    o_rec.q_ticks      = 8'd0;
                    o_rec.stamp        = i_ctl.counter;
                    o_res.add_take     = 1'b1;
                end
            end
            tlfs_pkg::PH_PICK: begin
                o_res.fast_better  = queued && !i_rec.in_smart &&
                                     (!i_ctl.bf_found || fast_wins);
                o_res.smart_better = queued && i_rec.in_smart &&
                                     (!i_ctl.bs_found || lhs > rhs ||
                                      (lhs == rhs && i_rec.stamp < i_ctl.bs_stamp));
            end
            tlfs_pkg::PH_UPDATE: begin
                if (queued) begin
                    if (i_ctl.leave && i_rec.stamp > i_ctl.pick_stamp) begin
                        o_rec.stamp = i_rec.stamp - 16'd1;
                    end
                    if (i_rec.wait_ticks != tlfs_pkg::WAIT_MAX) begin
                        o_rec.wait_ticks = i_rec.wait_ticks + 32'd1;
                    end
                end
                if (i_ctl.is_run) begin
                    o_rec.run_ticks    = run_inc;
                    o_rec.q_ticks      = qu_inc;
                    o_rec.in_smart     = 1'b0;
                    if (run_inc >= i_rec.burst) begin
                        o_rec.valid    = 1'b0;
                        o_res.finished = 1'b1;
                    end else if (qu_inc >= i_ctl.quantum) begin
                        o_rec.q_ticks      = 8'd0;
                        o_rec.in_smart     = 1'b1;
                        o_rec.stamp        = i_ctl.counter;
                        o_res.demoted      = 1'b1;
                    end
                end
            end
            default: begin
                o_rec = i_rec;
            end
        endcase
    end

endmodule
